[rtl/core/edf_periodic_task_scheduler_top_macros.svh]
`ifndef EDF_PERIODIC_TASK_SCHEDULER_TOP_MACROS_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_TOP_MACROS_SVH

// implication checked every clock edge outside reset
`define EDFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define EDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/edfs_pkg.sv]
package edfs_pkg;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned NUM_W   = 5;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [VAL_W-1:0] job_length;
    logic [VAL_W-1:0] release_interval;
    logic [VAL_W-1:0] relative_due;
  } cfg_entry_t;

  typedef struct packed {
    logic [VAL_W-1:0]  work_left;
    logic [TIME_W-1:0] release_at;
    logic [TIME_W-1:0] absolute_due;
  } dyn_entry_t;

endpackage

[rtl/core/edfs_in_if.sv]
interface edfs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [edfs_pkg::SLOT_W-1:0]   task_slot;
  logic [edfs_pkg::VAL_W-1:0]    job_ticks;
  logic [edfs_pkg::VAL_W-1:0]    period;
  logic [edfs_pkg::VAL_W-1:0]    rel_deadline;

  modport source (output valid, action, task_slot, job_ticks, period, rel_deadline,
                  input ready);
  modport sink (input valid, action, task_slot, job_ticks, period, rel_deadline,
                output ready);
endinterface

[rtl/core/edfs_out_if.sv]
interface edfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [edfs_pkg::TIME_W-1:0]   tick_time;
  logic [edfs_pkg::NUM_W-1:0]    task_number;

  modport source (output valid, tick_time, task_number, input ready);
  modport sink (input valid, tick_time, task_number, output ready);
endinterface

[rtl/core/edf_periodic_task_scheduler_top.sv]
// channel   | dir | transaction
// in_ch     | in  | tick (action 0) or task slot load (action 1)
// out_ch    | out | one result per tick: tick_time, task_number
// cfg_*     | in  | task_count write, taken on cfg_we
//
// a load leaves the input ready; a tick holds the input off until it finishes, reading each
// active slot in turn from the task entry memory through its single read port
// the finished result sits in an output register; a stalled output holds the tick in its
// final state until the register frees up
// synchronous active-low reset clears time, count, entry valid bits and control state
`include "edf_periodic_task_scheduler_top_macros.svh"

module edf_periodic_task_scheduler_top #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  edfs_in_if.sink                          in_ch,
  edfs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [edfs_pkg::COUNT_W-1:0]     cfg_wdata
);

  localparam int unsigned IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W0 = $clog2(MAX_TASKS + 1);
  localparam int unsigned CW     = (CNT_W0 > edfs_pkg::COUNT_W) ? CNT_W0 : edfs_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  edfs_pkg::cfg_entry_t cfg_mem [MAX_TASKS];
  edfs_pkg::dyn_entry_t dyn_mem [MAX_TASKS];

  logic [1:0]                         state_r, state_nxt;
  logic [CW-1:0]                      rd_cnt_r, rd_cnt_nxt;
  logic                               p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]                   p_idx_r, p_idx_nxt;
  logic                               found_r, found_nxt;
  logic [IDX_W-1:0]                   best_idx_r, best_idx_nxt;
  edfs_pkg::dyn_entry_t               best_r, best_nxt;
  logic [edfs_pkg::TIME_W-1:0]        now_r, now_nxt;
  logic [edfs_pkg::COUNT_W-1:0]       task_count_r;
  logic [MAX_TASKS-1:0]               vld_r, vld_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [edfs_pkg::TIME_W-1:0]        out_time_r;
  logic [edfs_pkg::NUM_W-1:0]         out_num_r;

  edfs_pkg::cfg_entry_t               cfg_q_r;
  edfs_pkg::dyn_entry_t               dyn_q_r;

  logic [CW-1:0]                      tc_ext, cnt_eff;
  logic [CW-1:0]                      slot_ext;
  logic [IDX_W-1:0]                   slot_idx;
  logic                               slot_ok;
  logic                               in_acc, load_acc, tick_acc;
  logic                               rd_en;
  logic [IDX_W-1:0]                   rd_addr;
  logic                               out_free, finish;
  edfs_pkg::dyn_entry_t               cur, upd;
  logic                               hit, better;
  logic                               dyn_we;
  logic [IDX_W-1:0]                   dyn_wa;
  edfs_pkg::dyn_entry_t               dyn_wd;
  logic [CW-1:0]                      num_sum;

  assign tc_ext   = CW'(task_count_r);
  assign cnt_eff  = (tc_ext > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : tc_ext;
  assign slot_ext = CW'(in_ch.task_slot);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = slot_ext < CW'(MAX_TASKS);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_acc    = in_acc && in_ch.action;
  assign tick_acc    = in_acc && !in_ch.action;

  assign rd_en    = (state_r == ST_SCAN) && (rd_cnt_r < cnt_eff);
  assign rd_addr  = rd_cnt_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_DONE) && out_free;

  // release check and candidate compare on the entry just read
  always_comb begin
    cur = vld_r[p_idx_r] ? dyn_q_r : '0;
    hit = (cur.release_at == now_r);
    upd = cur;
    if (hit) begin
      upd.work_left    = cfg_q_r.job_length;
      upd.absolute_due = now_r + edfs_pkg::TIME_W'(cfg_q_r.relative_due);
      upd.release_at   = cur.release_at + edfs_pkg::TIME_W'(cfg_q_r.release_interval);
    end
    better = p_vld_r && (upd.work_left != '0) &&
             (!found_r || (upd.absolute_due < best_r.absolute_due));
  end

  always_comb begin
    dyn_we = 1'b0;
    dyn_wa = p_idx_r;
    dyn_wd = upd;
    if (p_vld_r) begin
      dyn_we = 1'b1;
    end else if (finish && found_r) begin
      dyn_we           = 1'b1;
      dyn_wa           = best_idx_r;
      dyn_wd           = best_r;
      dyn_wd.work_left = best_r.work_left - edfs_pkg::VAL_W'(1);
    end
  end

  assign num_sum = CW'(best_idx_r) + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    p_vld_nxt     = 1'b0;
    p_idx_nxt     = rd_addr;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    now_nxt       = now_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (better) begin
      found_nxt    = 1'b1;
      best_idx_nxt = p_idx_r;
      best_nxt     = upd;
    end
    if (p_vld_r) begin
      vld_nxt[p_idx_r] = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (load_acc && slot_ok) begin
          vld_nxt[slot_idx] = 1'b0;
        end
        if (tick_acc) begin
          state_nxt  = ST_SCAN;
          rd_cnt_nxt = '0;
          found_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          p_vld_nxt  = 1'b1;
        end else if (!p_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          now_nxt       = now_r + edfs_pkg::TIME_W'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      p_vld_r      <= 1'b0;
      found_r      <= 1'b0;
      now_r        <= '0;
      task_count_r <= '0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      found_r     <= found_nxt;
      now_r       <= now_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r    <= p_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    if (finish) begin
      out_time_r <= now_r;
      out_num_r  <= found_r ? num_sum[edfs_pkg::NUM_W-1:0] : '0;
    end
  end

  // task parameter memory
  always_ff @(posedge clk) begin
    if (load_acc && slot_ok) begin
      cfg_mem[slot_idx] <= '{job_length:       in_ch.job_ticks,
                             release_interval: in_ch.period,
                             relative_due:     in_ch.rel_deadline};
    end
    if (rd_en) begin
      cfg_q_r <= cfg_mem[rd_addr];
    end
  end

  // job state memory
  always_ff @(posedge clk) begin
    if (dyn_we) begin
      dyn_mem[dyn_wa] <= dyn_wd;
    end
    if (rd_en) begin
      dyn_q_r <= dyn_mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tick_time   = out_time_r;
  assign out_ch.task_number = out_num_r;

  `EDFS_ASSERT_IMP(a_scan_in_range, clk, rst_n, p_vld_r, (CW'(p_idx_r) < cnt_eff), "slot beyond active count")
  `EDFS_ASSERT_IMP(a_best_pending, clk, rst_n, found_r, (best_r.work_left != '0), "picked task has no work")
  `EDFS_ASSERT_NEXT(a_time_step, clk, rst_n, finish, (now_r == $past(now_r) + edfs_pkg::TIME_W'(1)), "time did not advance")
  `EDFS_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), ($past(state_r) == ST_DONE), "result without finished tick")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_SLOTS    = 16;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_START   = 1500;
  localparam int unsigned HOLD_LENGTH  = 600;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } sched_action_e;

  typedef struct packed {
    sched_action_e               action;
    logic [edfs_pkg::SLOT_W-1:0] task_slot;
    logic [edfs_pkg::VAL_W-1:0]  job_ticks;
    logic [edfs_pkg::VAL_W-1:0]  period;
    logic [edfs_pkg::VAL_W-1:0]  rel_deadline;
  } sched_item_t;

  typedef struct packed {
    logic [edfs_pkg::TIME_W-1:0] tick_time;
    logic [edfs_pkg::NUM_W-1:0]  task_number;
  } sched_result_t;

  typedef struct {
    sched_item_t   item;
    bit            typed;
    sched_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [edfs_pkg::COUNT_W-1:0] cfg_wdata;

  edfs_in_if  in_if ();
  edfs_out_if out_if ();

  edf_periodic_task_scheduler_top #(
    .MAX_TASKS(MAX_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler state as the block should hold it
  logic [edfs_pkg::COUNT_W-1:0] task_count_q;
  logic [edfs_pkg::TIME_W-1:0]  sched_now;
  edfs_pkg::cfg_entry_t         slot_cfg [MAX_SLOTS];
  edfs_pkg::dyn_entry_t         slot_dyn [MAX_SLOTS];

  sched_result_t tick_results_q [$];
  stim_row_t     dir_tab [$];
  int unsigned   mismatches = 0;
  int unsigned   burst_left;
  int unsigned   cycle_count = 0;
  int unsigned   rx_cycle;
  int unsigned   hold_left;
  sched_result_t want;

  function automatic bit schedule_item(input sched_item_t it, output sched_result_t res);
    int unsigned active;
    int unsigned pick;
    bit found;
    res = '0;
    pick = 0;
    found = 1'b0;
    active = (task_count_q > edfs_pkg::COUNT_W'(MAX_SLOTS)) ? MAX_SLOTS : 32'(task_count_q);
    if (it.action == ACT_LOAD) begin
      slot_cfg[it.task_slot].job_length       = it.job_ticks;
      slot_cfg[it.task_slot].release_interval = it.period;
      slot_cfg[it.task_slot].relative_due     = it.rel_deadline;
      slot_dyn[it.task_slot].work_left        = '0;
      slot_dyn[it.task_slot].release_at       = '0;
      return 1'b0;
    end
    for (int i = 0; i < active; i++) begin
      if (slot_dyn[i].release_at == sched_now) begin
        slot_dyn[i].work_left    = slot_cfg[i].job_length;
        slot_dyn[i].absolute_due = sched_now + edfs_pkg::TIME_W'(slot_cfg[i].relative_due);
        slot_dyn[i].release_at   = slot_dyn[i].release_at +
                                   edfs_pkg::TIME_W'(slot_cfg[i].release_interval);
      end
    end
    for (int i = 0; i < active; i++) begin
      if (slot_dyn[i].work_left != '0 &&
          (!found || slot_dyn[i].absolute_due < slot_dyn[pick].absolute_due)) begin
        pick  = i;
        found = 1'b1;
      end
    end
    res.tick_time = sched_now;
    if (found) begin
      slot_dyn[pick].work_left = slot_dyn[pick].work_left - edfs_pkg::VAL_W'(1);
      res.task_number = edfs_pkg::NUM_W'(pick + 1);
    end
    sched_now = sched_now + edfs_pkg::TIME_W'(1);
    return 1'b1;
  endfunction

  function automatic stim_row_t dir_row(sched_action_e act, int unsigned slot,
                                        int unsigned ex, int unsigned per, int unsigned dl,
                                        bit typed, int unsigned t, int unsigned num);
    stim_row_t r;
    r.item.action       = act;
    r.item.task_slot    = edfs_pkg::SLOT_W'(slot);
    r.item.job_ticks    = edfs_pkg::VAL_W'(ex);
    r.item.period       = edfs_pkg::VAL_W'(per);
    r.item.rel_deadline = edfs_pkg::VAL_W'(dl);
    r.typed             = typed;
    r.want.tick_time    = edfs_pkg::TIME_W'(t);
    r.want.task_number  = edfs_pkg::NUM_W'(num);
    return r;
  endfunction

  function automatic sched_item_t random_item(int unsigned load_pct);
    sched_item_t it;
    it.action       = ($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_TICK;
    it.task_slot    = edfs_pkg::SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
    it.job_ticks    = $urandom_range(0, 1) ? edfs_pkg::VAL_W'($urandom) :
                                             edfs_pkg::VAL_W'($urandom_range(0, 6));
    it.period       = $urandom_range(0, 1) ? edfs_pkg::VAL_W'($urandom) :
                                             edfs_pkg::VAL_W'($urandom_range(0, 30));
    it.rel_deadline = $urandom_range(0, 1) ? edfs_pkg::VAL_W'($urandom) :
                                             edfs_pkg::VAL_W'($urandom_range(0, 30));
    return it;
  endfunction

  task automatic push_item(input sched_item_t it, input bit typed, input sched_result_t typed_res);
    sched_result_t res;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 20);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.task_slot    <= it.task_slot;
    in_if.job_ticks    <= it.job_ticks;
    in_if.period       <= it.period;
    in_if.rel_deadline <= it.rel_deadline;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    if (schedule_item(it, res))
      tick_results_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_task_count(input logic [edfs_pkg::COUNT_W-1:0] value);
    in_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    task_count_q = value;
    burst_left = 0;
  endtask

  task automatic random_phase(input logic [edfs_pkg::COUNT_W-1:0] count,
                              input int unsigned items, input int unsigned load_pct);
    write_task_count(count);
    repeat (items) push_item(random_item(load_pct), 1'b0, '0);
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual time %0d task %0d",
                 $time, out_if.tick_time, out_if.task_number);
        mismatches++;
      end else begin
        want = tick_results_q.pop_front();
        if (out_if.tick_time !== want.tick_time) begin
          $display("%0t: tick_time expected %0d actual %0d",
                   $time, want.tick_time, out_if.tick_time);
          mismatches++;
        end
        if (out_if.task_number !== want.task_number) begin
          $display("%0t: task_number at time %0d expected %0d actual %0d",
                   $time, want.tick_time, want.task_number, out_if.task_number);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycle     <= 0;
      hold_left    <= 0;
      out_if.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_cycle == HOLD_START) begin
        hold_left <= HOLD_LENGTH;
        out_if.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= (rx_cycle % 4) != 3;
          2: out_if.ready <= $urandom_range(0, 2) == 0;
          default: out_if.ready <= (rx_cycle % 7) < 2;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_TICK;
    in_if.task_slot    = '0;
    in_if.job_ticks    = '0;
    in_if.period       = '0;
    in_if.rel_deadline = '0;
    burst_left         = 0;
    task_count_q       = '0;
    sched_now          = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_cfg[i] = '0;
      slot_dyn[i] = '0;
    end

    // all slots loaded at time zero so that every count is safe to tick
    dir_tab.push_back(dir_row(ACT_LOAD, 0, 1, 16'hFFFF, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 3, 3, 0, 5, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 4, 2, 7, 7, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 5, 2, 7, 7, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 6, 1, 10, 10, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 7, 2, 12, 9, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 8, 1, 16, 16, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 9, 3, 20, 15, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 10, 1, 8, 8, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 11, 2, 25, 20, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 12, 1, 30, 30, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 13, 4, 40, 35, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 14, 1, 50, 50, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_LOAD, 15, 2, 64, 60, 0, 0, 0));
    dir_tab.push_back(dir_row(ACT_TICK, 0, 0, 0, 0, 1, 0, 1));
    dir_tab.push_back(dir_row(ACT_TICK, 0, 0, 0, 0, 1, 1, 4));
    repeat (4) dir_tab.push_back(dir_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    // late load: slot never releases again before time wraps
    dir_tab.push_back(dir_row(ACT_LOAD, 14, 5, 3, 2, 0, 0, 0));
    repeat (2) dir_tab.push_back(dir_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_task_count(edfs_pkg::COUNT_W'(MAX_SLOTS));
    foreach (dir_tab[i]) push_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    random_phase(edfs_pkg::COUNT_W'(MAX_SLOTS), 250, 3);
    random_phase('1, 150, 4);
    random_phase(edfs_pkg::COUNT_W'($urandom_range(2, MAX_SLOTS - 1)), 100, 8);
    random_phase(edfs_pkg::COUNT_W'(1), 60, 10);
    random_phase('0, 40, 15);

    in_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/edfs_pkg.sv
rtl/core/edfs_in_if.sv
rtl/core/edfs_out_if.sv
rtl/core/edf_periodic_task_scheduler_top.sv
tb/tb_top.sv
